// File: hw/rtl/axis_and_heading_ema_smoother_macros.svh
// assertion macros shared by the smoother rtl
`ifndef AXIS_AND_HEADING_EMA_SMOOTHER_MACROS_SVH
`define AXIS_AND_HEADING_EMA_SMOOTHER_MACROS_SVH

// same-cycle implication, checked on clk while out of reset
`define AESM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk while out of reset
`define AESM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/aesm_pkg.sv
// types, constants and helpers for the axis and heading smoother
package aesm_pkg;

  localparam int AXIS_ONE     = 16384;
  localparam int ALPHA_ONE    = 65536;
  localparam int HEAD_FULL    = 36000;
  localparam int HEAD_HALF    = 18000;
  localparam int STICK_CENTRE = 127;
  // 16384 = 127 * 129 + 1, so d * 16384 / 127 is d * 129 for |d| < 127
  localparam int STICK_GAIN   = 129;

  localparam int WEIGHT_W = 17;
  localparam int GAIN_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 17;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN       = 8'd1;

  typedef struct packed {
    logic [15:0] heading_in;
    logic [7:0]  stick_x_raw;
    logic [7:0]  stick_y_raw;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] axis_x_smooth;
    logic signed [15:0] axis_y_smooth;
    logic        [15:0] heading_smooth;
    logic signed [15:0] joy_x_out;
    logic signed [15:0] joy_y_out;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMA_X,
    ST_EMA_Y,
    ST_HEAD,
    ST_JOY_X,
    ST_JOY_Y,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_EMA_X,
    OP_EMA_Y,
    OP_HEAD,
    OP_JOY_X,
    OP_JOY_Y
  } op_t;

  typedef struct packed {
    op_t  op;
    logic mul_en;
    logic upd_x;
    logic upd_y;
    logic upd_h;
    logic upd_jx;
    logic fin;
  } ctl_t;

  // centred stick offset (-128..128) to clamped Q2.14 axis
  function automatic logic signed [15:0] stick_axis(input logic signed [8:0] d);
    logic signed [15:0] r;
    if (d >= 9'(STICK_CENTRE)) begin
      r = 16'(AXIS_ONE);
    end else if (d <= -9'(STICK_CENTRE)) begin
      r = -16'(AXIS_ONE);
    end else begin
      r = 16'(d * 16'(STICK_GAIN));
    end
    return r;
  endfunction

  // gain product shifted down by 8 and saturated to +-1.0
  function automatic logic signed [15:0] clamp_joy(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-9:0] v;
    logic signed [15:0]       r;
    v = p[PROD_W-1:8];
    if (v > (PROD_W-8)'(AXIS_ONE)) begin
      r = 16'(AXIS_ONE);
    end else if (v < -(PROD_W-8)'(AXIS_ONE)) begin
      r = -16'(AXIS_ONE);
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/aesm_mul.sv
// shared signed multiplier with registered product
module aesm_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [aesm_pkg::MUL_W-1:0]   a,
  input  logic signed [aesm_pkg::MUL_W-1:0]   b,
  output logic signed [aesm_pkg::PROD_W-1:0]  prod
);
  import aesm_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;

  // one product per enabled cycle
  assign prod_nxt = en ? (a * b) : prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// File: hw/rtl/aesm_ctrl.sv
// sequencer stepping the shared multiplier through the five products
`include "axis_and_heading_ema_smoother_macros.svh"

module aesm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           out_free,
  output logic           busy,
  output aesm_pkg::ctl_t ctl
);
  import aesm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_EMA_X;
      ST_EMA_X: state_nxt = ST_EMA_Y;
      ST_EMA_Y: state_nxt = ST_HEAD;
      ST_HEAD:  state_nxt = ST_JOY_X;
      ST_JOY_X: state_nxt = ST_JOY_Y;
      ST_JOY_Y: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // outputs per state
  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_EMA_X: begin
        ctl.op     = OP_EMA_X;
        ctl.mul_en = 1'b1;
      end
      ST_EMA_Y: begin
        ctl.op     = OP_EMA_Y;
        ctl.mul_en = 1'b1;
        ctl.upd_x  = 1'b1;
      end
      ST_HEAD: begin
        ctl.op     = OP_HEAD;
        ctl.mul_en = 1'b1;
        ctl.upd_y  = 1'b1;
      end
      ST_JOY_X: begin
        ctl.op     = OP_JOY_X;
        ctl.mul_en = 1'b1;
        ctl.upd_h  = 1'b1;
      end
      ST_JOY_Y: begin
        ctl.op     = OP_JOY_Y;
        ctl.mul_en = 1'b1;
        ctl.upd_jx = 1'b1;
      end
      ST_DONE: begin
        ctl.fin = out_free;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `AESM_ASSERT_NEXT(a_start_seq, (state_r == ST_IDLE) && start, state_r == ST_EMA_X, "start did not enter the product sequence")
  `AESM_ASSERT_NOW(a_fin_free, ctl.fin, out_free && (state_r == ST_DONE), "result loaded while output register busy")
  `AESM_ASSERT_NOW(a_upd_onehot, 1'b1, $onehot0({ctl.upd_x, ctl.upd_y, ctl.upd_h, ctl.upd_jx, ctl.fin}), "more than one update strobe")

endmodule

// File: hw/rtl/axis_and_heading_ema_smoother.sv
// top level: stick and heading smoother with ema over one shared multiplier
//
// Input channel in_valid/in_stall/in_data carries one sample beat: heading in
// hundredths of a degree and two raw stick bytes. Output channel
// out_valid/out_stall/out_data carries one result beat per sample: both
// smoothed axes, the smoothed heading and the two gained joystick axes.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes the smoothing weight (index 0)
// and the speed gain (index 1); other indexes are dropped. cfg_ready is
// always high; write only while no sample is in flight.
// Each sample runs five products through one shared 18x18 multiplier, one per
// cycle, with an add stage behind each average product and a clamp behind each
// joystick product. A new sample is taken only once the last one has finished;
// in_stall is high while the sequencer is busy.
// If the receiver stalls, the result holds in the output register; a next
// sample may be accepted meanwhile but completes only once that beat is taken.
// Synchronous reset clears the averages to zero, restores the register
// defaults (weight 19661, gain 256) and empties the output register.
`include "axis_and_heading_ema_smoother_macros.svh"

module axis_and_heading_ema_smoother (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  aesm_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output aesm_pkg::out_beat_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aesm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aesm_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import aesm_pkg::*;

  ctl_t ctl;
  logic busy;
  logic out_free;
  logic in_acc;

  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;

  logic [WEIGHT_W-1:0] alpha_r;
  logic [15:0]         h_r;
  logic signed [15:0]  rawx_r, rawy_r;

  logic signed [15:0]  xavg_r, xavg_nxt;
  logic signed [15:0]  yavg_r, yavg_nxt;
  logic [15:0]         havg_r, havg_nxt;
  logic signed [15:0]  jx_r;

  out_beat_t out_r;
  logic      out_valid_r, out_valid_nxt;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  step;
  logic signed [MUL_W-1:0]  hdiff_raw, hdiff;
  logic signed [MUL_W-1:0]  hsum;
  logic [15:0]              h_mod;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_acc    = in_valid && !busy;
  assign out_free  = !out_valid_r || !out_stall;

  // configuration registers
  always_comb begin
    weight_nxt = weight_r;
    gain_nxt   = gain_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SMOOTHING_WEIGHT: weight_nxt = cfg_data[WEIGHT_W-1:0];
        REG_SPEED_GAIN:       gain_nxt   = cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_W'(19661);
      gain_r   <= GAIN_W'(256);
    end else begin
      weight_r <= weight_nxt;
      gain_r   <= gain_nxt;
    end
  end

  // heading folded into one turn
  assign h_mod = (in_data.heading_in >= 16'(HEAD_FULL)) ?
                 (in_data.heading_in - 16'(HEAD_FULL)) : in_data.heading_in;

  // sample capture: centred sticks, saturated weight
  always_ff @(posedge clk) begin
    if (in_acc) begin
      h_r     <= h_mod;
      rawx_r  <= stick_axis($signed({1'b0, in_data.stick_x_raw}) - 9'(STICK_CENTRE));
      rawy_r  <= stick_axis(9'(STICK_CENTRE) - $signed({1'b0, in_data.stick_y_raw}));
      alpha_r <= (weight_r > WEIGHT_W'(ALPHA_ONE)) ? WEIGHT_W'(ALPHA_ONE) : weight_r;
    end
  end

  aesm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  // shortest-arc heading difference
  assign hdiff_raw = $signed({2'b00, h_r}) - $signed({2'b00, havg_r});
  always_comb begin
    hdiff = hdiff_raw;
    if (hdiff_raw > MUL_W'(HEAD_HALF)) begin
      hdiff = hdiff_raw - MUL_W'(HEAD_FULL);
    end else if (hdiff_raw < -MUL_W'(HEAD_HALF)) begin
      hdiff = hdiff_raw + MUL_W'(HEAD_FULL);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = $signed({1'b0, alpha_r});
    mul_b = '0;
    case (ctl.op)
      OP_EMA_X: mul_b = $signed({{2{rawx_r[15]}}, rawx_r})
                      - $signed({{2{xavg_r[15]}}, xavg_r});
      OP_EMA_Y: mul_b = $signed({{2{rawy_r[15]}}, rawy_r})
                      - $signed({{2{yavg_r[15]}}, yavg_r});
      OP_HEAD:  mul_b = hdiff;
      OP_JOY_X: begin
        mul_a = $signed({2'b00, gain_r});
        mul_b = $signed({{2{xavg_r[15]}}, xavg_r});
      end
      OP_JOY_Y: begin
        mul_a = $signed({2'b00, gain_r});
        mul_b = $signed({{2{yavg_r[15]}}, yavg_r});
      end
      default: mul_b = '0;
    endcase
  end

  aesm_mul u_mul (
    .clk  (clk),
    .en   (ctl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // weighted step, floor of product over 2^16
  assign step = prod[MUL_W+15:16];
  assign hsum = $signed({2'b00, havg_r}) + step;

  // average updates
  always_comb begin
    xavg_nxt = xavg_r;
    yavg_nxt = yavg_r;
    havg_nxt = havg_r;
    if (ctl.upd_x) begin
      xavg_nxt = 16'(xavg_r + step);
    end
    if (ctl.upd_y) begin
      yavg_nxt = 16'(yavg_r + step);
    end
    if (ctl.upd_h) begin
      if (hsum < 0) begin
        havg_nxt = 16'(hsum + MUL_W'(HEAD_FULL));
      end else if (hsum >= MUL_W'(HEAD_FULL)) begin
        havg_nxt = 16'(hsum - MUL_W'(HEAD_FULL));
      end else begin
        havg_nxt = hsum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xavg_r <= '0;
      yavg_r <= '0;
      havg_r <= '0;
    end else begin
      xavg_r <= xavg_nxt;
      yavg_r <= yavg_nxt;
      havg_r <= havg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd_jx) begin
      jx_r <= clamp_joy(prod);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.fin) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      out_r.axis_x_smooth  <= xavg_r;
      out_r.axis_y_smooth  <= yavg_r;
      out_r.heading_smooth <= havg_r;
      out_r.joy_x_out      <= jx_r;
      out_r.joy_y_out      <= clamp_joy(prod);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `AESM_ASSERT_NOW(a_head_range, 1'b1, havg_r < 16'(HEAD_FULL), "heading average left one turn")
  `AESM_ASSERT_NOW(a_axis_range, 1'b1, (xavg_r <= 16'(AXIS_ONE)) && (xavg_r >= -16'(AXIS_ONE)), "x average beyond unit range")
  `AESM_ASSERT_NOW(a_busy_hold, busy, !in_acc, "sample taken while sequencer busy")

endmodule
